// ===== rtl/oeu_pkg.sv =====
`timescale 1ns / 1ps

package oeu_pkg;

	// Action codes carried in s_tuser
	localparam logic ACT_LOAD     = 1'b0;
	localparam logic ACT_INTERACT = 1'b1;

	// Configuration register indexes
	localparam logic REG_GAIN      = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	localparam int GAIN_W  = 14;
	localparam int THR_W   = 16;
	localparam int IDX_W   = 11;
	localparam int PRIV_W  = 16;
	localparam int MAG_W   = 13;
	localparam int ZERO_W  = 12;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd6144;
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd9830;

	// Q1.14 unity
	localparam logic signed [PRIV_W-1:0] Q_ONE = 16'sd16384;

	// Queue between front and back
	localparam int QDEPTH_LG = 2;
	localparam int QDEPTH    = 1 << QDEPTH_LG;

	// Classified item as it leaves the front
	typedef struct packed {
		logic                     action;
		logic                     agent_ok;
		logic                     partner_ok;
		logic                     neg;
		logic [IDX_W-1:0]         agent;
		logic [IDX_W-1:0]         partner;
		logic signed [1:0]        load_pub;
		logic signed [PRIV_W-1:0] load_priv;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [ZERO_W-1:0]        zero_count;
		logic signed [MAG_W-1:0]  magnetization;
		logic signed [PRIV_W-1:0] private_after;
		logic signed [1:0]        public_after;
	} result_t;

endpackage

// ===== rtl/oeu_front.sv =====
`timescale 1ns / 1ps

module oeu_front #(
	parameter int AGENTS = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [oeu_pkg::IDX_W-1:0]      agent_index,
	input  logic [oeu_pkg::IDX_W-1:0]      partner_index,
	input  logic                           negative_interaction,
	input  logic signed [1:0]              load_public,
	input  logic signed [oeu_pkg::PRIV_W-1:0] load_private,
	input  logic                           hold,
	output logic                           push,
	input  logic                           q_full,
	output oeu_pkg::item_t                 item
);

	logic           valid_s1;
	oeu_pkg::item_t item_s1;
	oeu_pkg::item_t cls;

	// Classify: range checks, saturate the -2 pattern, clamp private opinion
	always_comb begin
		cls            = '0;
		cls.action     = action;
		cls.agent_ok   = (32'(agent_index) < AGENTS);
		cls.partner_ok = (32'(partner_index) < AGENTS);
		cls.neg        = negative_interaction;
		cls.agent      = agent_index;
		cls.partner    = partner_index;
		cls.load_pub   = (load_public == -2'sd2) ? -2'sd1 : load_public;
		if (load_private > oeu_pkg::Q_ONE) begin
			cls.load_priv = oeu_pkg::Q_ONE;
		end else if (load_private < -oeu_pkg::Q_ONE) begin
			cls.load_priv = -oeu_pkg::Q_ONE;
		end else begin
			cls.load_priv = load_private;
		end
	end

	assign push     = valid_s1 && !q_full;
	assign in_ready = !hold && (!valid_s1 || !q_full);
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== rtl/oeu_fifo.sv =====
`timescale 1ns / 1ps

module oeu_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  oeu_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output oeu_pkg::item_t rd_item
);

	oeu_pkg::item_t                 slot_q [oeu_pkg::QDEPTH];
	logic [oeu_pkg::QDEPTH_LG-1:0]  wr_ptr_q;
	logic [oeu_pkg::QDEPTH_LG-1:0]  rd_ptr_q;
	logic [oeu_pkg::QDEPTH_LG:0]    cnt_q;

	assign full      = (cnt_q == (oeu_pkg::QDEPTH_LG + 1)'(oeu_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/oeu_back.sv =====
`timescale 1ns / 1ps

module oeu_back #(
	parameter int AGENTS = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [oeu_pkg::GAIN_W-1:0]     gain,
	input  logic [oeu_pkg::THR_W-1:0]      thr,
	input  logic                           q_valid,
	input  oeu_pkg::item_t                 q_item,
	output logic                           pop,
	output logic                           clearing,
	output logic                           out_valid,
	input  logic                           out_ready,
	output oeu_pkg::result_t               out_res
);

	localparam int AW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
	localparam logic [AW-1:0] LAST = AW'(AGENTS - 1);
	localparam logic signed [18:0] QH19 = 19'sd16384;
	localparam logic signed [17:0] QH18 = 18'sd16384;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC, S_WRITE} state_t;

	state_t                            state_q;
	logic [AW-1:0]                     clr_q;
	oeu_pkg::item_t                    item_q;
	logic signed [1:0]                 old_q;
	logic signed [1:0]                 ptn_q;
	logic signed [oeu_pkg::PRIV_W-1:0] priv_q;
	logic signed [1:0]                 np_q;
	logic signed [oeu_pkg::PRIV_W-1:0] qv_q;
	logic signed [oeu_pkg::MAG_W-1:0]  sum_q;
	logic [oeu_pkg::ZERO_W-1:0]        zero_q;
	logic                              out_valid_q;
	oeu_pkg::result_t                  res_q;

	logic signed [1:0]                 pub_mem  [AGENTS];
	logic signed [oeu_pkg::PRIV_W-1:0] priv_mem [AGENTS];

	logic                              slot_free;
	logic                              commit;
	logic                              mem_we;
	logic [AW-1:0]                     mem_waddr;
	logic signed [1:0]                 mem_wpub;
	logic signed [oeu_pkg::PRIV_W-1:0] mem_wpriv;

	// calc stage
	logic signed [1:0]  partner;
	logic signed [2:0]  psum;
	logic signed [1:0]  np_c;
	logic signed [2:0]  dp;
	logic [15:0]        gain4;
	logic [16:0]        mag17;
	logic signed [18:0] delta;
	logic signed [18:0] q19;
	logic signed [oeu_pkg::PRIV_W-1:0] qc;

	// write stage
	logic signed [17:0] npq;
	logic signed [17:0] gap;
	logic [16:0]        gap_abs;
	logic signed [1:0]  np_fin;
	logic signed [2:0]  dsum;
	logic [oeu_pkg::ZERO_W-1:0]       zero_n;
	logic signed [oeu_pkg::MAG_W-1:0] sum_n;

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign clearing  = (state_q == S_CLEAR);
	assign commit    = (state_q == S_WRITE) && slot_free;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		partner = item_q.partner_ok ? ptn_q : 2'sd0;
		psum    = 3'(old_q) + (item_q.neg ? -3'(partner) : 3'(partner));
		if (psum > 3'sd1) begin
			np_c = 2'sd1;
		end else if (psum < -3'sd1) begin
			np_c = -2'sd1;
		end else begin
			np_c = 2'(psum);
		end
		dp    = 3'(np_c) - 3'(old_q);
		gain4 = {gain, 2'b00};
		case (dp)
			3'sd1, -3'sd1: mag17 = {1'b0, gain4};
			3'sd2, -3'sd2: mag17 = {gain4, 1'b0};
			default:       mag17 = '0;
		endcase
		delta = dp[2] ? -$signed({2'b00, mag17}) : $signed({2'b00, mag17});
		q19   = 19'(priv_q) + delta;
		if (q19 > QH19) begin
			qc = oeu_pkg::Q_ONE;
		end else if (q19 < -QH19) begin
			qc = -oeu_pkg::Q_ONE;
		end else begin
			qc = 16'(q19);
		end
	end

	// Interacts: a wide gap pulls public toward the sign of private
	always_comb begin
		case (np_q)
			2'sd1:   npq = QH18;
			-2'sd1:  npq = -QH18;
			default: npq = '0;
		endcase
		gap     = 18'(qv_q) - npq;
		gap_abs = gap[17] ? 17'(-gap) : 17'(gap);
		np_fin  = np_q;
		if (item_q.action == oeu_pkg::ACT_INTERACT && gap_abs > {1'b0, thr}) begin
			if (qv_q < 0) begin
				np_fin = -2'sd1;
			end else if (qv_q > 0) begin
				np_fin = 2'sd1;
			end
		end
		dsum   = 3'(np_fin) - 3'(old_q);
		sum_n  = sum_q + oeu_pkg::MAG_W'(dsum);
		zero_n = zero_q + oeu_pkg::ZERO_W'(np_fin == 2'sd0)
			- oeu_pkg::ZERO_W'(old_q == 2'sd0);
	end

	always_comb begin
		mem_we    = clearing || (commit && item_q.agent_ok);
		mem_waddr = clearing ? clr_q : AW'(item_q.agent);
		mem_wpub  = clearing ? 2'sd0 : np_fin;
		mem_wpriv = clearing ? '0 : qv_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pub_mem[mem_waddr]  <= mem_wpub;
			priv_mem[mem_waddr] <= mem_wpriv;
		end
		if (pop) begin
			old_q  <= pub_mem[AW'(q_item.agent)];
			ptn_q  <= pub_mem[AW'(q_item.partner)];
			priv_q <= priv_mem[AW'(q_item.agent)];
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sum_q       <= '0;
			zero_q      <= oeu_pkg::ZERO_W'(AGENTS);
			out_valid_q <= 1'b0;
			res_q       <= '0;
			np_q        <= '0;
			qv_q        <= '0;
		end else begin
			if (out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (item_q.action == oeu_pkg::ACT_LOAD) begin
						np_q <= item_q.load_pub;
						qv_q <= item_q.load_priv;
					end else begin
						np_q <= np_c;
						qv_q <= qc;
					end
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (item_q.agent_ok) begin
							sum_q                <= sum_n;
							zero_q               <= zero_n;
							res_q.public_after   <= np_fin;
							res_q.private_after  <= qv_q;
							res_q.magnetization  <= sum_n;
							res_q.zero_count     <= zero_n;
						end else begin
							res_q.public_after   <= '0;
							res_q.private_after  <= '0;
							res_q.magnetization  <= sum_q;
							res_q.zero_count     <= zero_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE)
		else $error("queue popped outside idle");
	a_out_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WRITE))
		else $error("result raised outside write step");
	a_sum_changes_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sum_q) |-> $past(state_q == S_WRITE))
		else $error("magnetization changed outside write step");
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !out_valid_q && !pop)
		else $error("activity during clearing pass");
`endif

endmodule

// ===== rtl/opinion_exchange_update_core.sv =====
`timescale 1ns / 1ps

// Opinion exchange update core. Keeps a public opinion (-1/0/+1) and a Q1.14
// private opinion per agent, plus a running magnetization and zero count.
// Each accepted beat (s_tuser = 0 load, 1 interact) yields exactly one result
// beat. After reset the block sweeps both opinion memories to zero, one entry
// per cycle; s_tready stays low during that pass while configuration writes
// are taken as usual. A front stage classifies beats into a 4-entry queue; the
// back sequencer does a read-modify-write over the opinion memories as read,
// compute and write/commit steps, and it pops the next item only once the last
// one has committed; the write step waits while an earlier result is not taken.
// On the way to the result stream a beat passes the front register, the
// queue, and the read, compute and write steps. gain_k and switch_threshold
// are written through cfg_* and should only change while the block is idle.
module opinion_exchange_update_core #(
	parameter int AGENTS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// agent_index[10:0], partner_index[21:11], negative_interaction[22],
	// load_public[24:23], load_private[40:25], zero pad [47:41]
	input  logic [47:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// public_after[1:0], private_after[17:2], magnetization[30:18],
	// zero_count[42:31], zero pad [47:43]
	output logic [47:0] m_tdata
);

	logic [oeu_pkg::GAIN_W-1:0] gain_q;
	logic [oeu_pkg::THR_W-1:0]  thr_q;

	logic             push;
	logic             q_full;
	logic             q_valid;
	logic             pop;
	logic             clearing;
	oeu_pkg::item_t   f_item;
	oeu_pkg::item_t   q_item;
	oeu_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= oeu_pkg::GAIN_RESET;
			thr_q  <= oeu_pkg::THR_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				oeu_pkg::REG_GAIN:      gain_q <= cfg_wdata[oeu_pkg::GAIN_W-1:0];
				oeu_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata;
				default:                thr_q  <= thr_q;
			endcase
		end
	end

	// Front: accept and classify; held off during the clearing pass
	oeu_front #(.AGENTS(AGENTS)) u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (s_tvalid),
		.in_ready             (s_tready),
		.action               (s_tuser),
		.agent_index          (s_tdata[10:0]),
		.partner_index        (s_tdata[21:11]),
		.negative_interaction (s_tdata[22]),
		.load_public          (s_tdata[24:23]),
		.load_private         (s_tdata[40:25]),
		.hold                 (clearing),
		.push                 (push),
		.q_full               (q_full),
		.item                 (f_item)
	);

	oeu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (f_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rd_item   (q_item)
	);

	// Back: memory read-modify-write, counters, output register
	oeu_back #(.AGENTS(AGENTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain_q),
		.thr       (thr_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'b0, res};

endmodule

// ===== bench/opinion_exchange_update_checker.sv =====
`timescale 1ns / 1ps

module opinion_exchange_update_checker
	import oeu_pkg::*;
#(
	parameter int AGENTS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          mismatches,
	output int          outstanding
);

	// shadow copy of the opinion state
	logic signed [1:0]        public_op  [AGENTS];
	logic signed [PRIV_W-1:0] private_op [AGENTS];
	int                       opinion_total;
	int                       neutral_agents;
	logic [GAIN_W-1:0]        gain;
	logic [THR_W-1:0]         threshold;

	result_t                  expected_opinions[$];
	int                       fail_count;

	function automatic int clip(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic set_public_op(input int a, input int v);
		opinion_total += v - int'(public_op[a]);
		if (public_op[a] == 0) neutral_agents--;
		if (v == 0) neutral_agents++;
		public_op[a] = 2'(v);
	endtask

	// apply one accepted beat to the shadow state, queue the result it implies
	task automatic predict_opinion_update(input logic act, input logic [47:0] d);
		int      ai;
		int      pj;
		int      old_pub;
		int      partner;
		int      np;
		int      q;
		int      gap;
		result_t r;
		ai = int'(d[10:0]);
		pj = int'(d[21:11]);
		r  = '0;
		if (ai < AGENTS) begin
			if (act == ACT_LOAD) begin
				// pattern 10 saturates to -1
				set_public_op(ai, d[24] ? -1 : int'(d[23]));
				private_op[ai] = PRIV_W'(clip(int'($signed(d[40:25])),
					-int'(Q_ONE), int'(Q_ONE)));
			end else begin
				old_pub = int'(public_op[ai]);
				partner = (pj < AGENTS) ? int'(public_op[pj]) : 0;
				np = clip(old_pub + (d[22] ? -partner : partner), -1, 1);
				q = int'(private_op[ai]) + int'(gain) * 4 * (np - old_pub);
				q = clip(q, -int'(Q_ONE), int'(Q_ONE));
				gap = q - np * int'(Q_ONE);
				if (gap < 0) gap = -gap;
				if (gap > int'(threshold)) begin
					if (q < 0) np = -1;
					else if (q > 0) np = 1;
				end
				set_public_op(ai, np);
				private_op[ai] = PRIV_W'(q);
			end
			r.public_after  = public_op[ai];
			r.private_after = private_op[ai];
		end
		r.magnetization = opinion_total[MAG_W-1:0];
		r.zero_count    = neutral_agents[ZERO_W-1:0];
		expected_opinions.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t seen;
		if (!arst_n) begin
			for (int a = 0; a < AGENTS; a++) begin
				public_op[a]  = '0;
				private_op[a] = '0;
			end
			opinion_total  = 0;
			neutral_agents = AGENTS;
			gain           = GAIN_RESET;
			threshold      = THR_RESET;
			expected_opinions.delete();
			fail_count     = 0;
			mismatches    <= 0;
			outstanding   <= 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == REG_GAIN) gain = cfg_wdata[GAIN_W-1:0];
				else threshold = cfg_wdata[THR_W-1:0];
			end
			// results are checked before the new input is predicted
			if (m_tvalid && m_tready) begin
				if (expected_opinions.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_opinions.pop_front();
					seen = m_tdata[$bits(result_t)-1:0];
					if (seen.public_after !== want.public_after) begin
						$error("public_after: expected %0d, got %0d",
							want.public_after, seen.public_after);
						fail_count++;
					end
					if (seen.private_after !== want.private_after) begin
						$error("private_after: expected %0d, got %0d",
							want.private_after, seen.private_after);
						fail_count++;
					end
					if (seen.magnetization !== want.magnetization) begin
						$error("magnetization: expected %0d, got %0d",
							want.magnetization, seen.magnetization);
						fail_count++;
					end
					if (seen.zero_count !== want.zero_count) begin
						$error("zero_count: expected %0d, got %0d",
							want.zero_count, seen.zero_count);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) predict_opinion_update(s_tuser, s_tdata);
			mismatches  <= fail_count;
			outstanding <= expected_opinions.size();
		end
	end

endmodule

// ===== bench/opinion_exchange_update_core_tb.sv =====
`timescale 1ns / 1ps

module opinion_exchange_update_core_tb;
	import oeu_pkg::*;

	localparam int AGENTS      = 2048;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 141;     // ~1130 random beats in total
	// clearing pass + ~1150 beats under random stalls, many times over
	localparam int CYCLE_LIMIT = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic        cfg_index = REG_GAIN;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic        s_tuser   = ACT_LOAD;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;

	int          check_failures;
	int          pending_results;
	int          cycle_count   = 0;
	int          send_idle_pct = 0;   // chance per cycle that the sender holds off
	int          recv_stall_pct = 0;  // chance per cycle that the sink stalls
	logic [10:0] last_agent    = '0;

	opinion_exchange_update_core #(
		.AGENTS(AGENTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	opinion_exchange_update_checker #(
		.AGENTS(AGENTS)
	) i_opinion_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (check_failures),
		.outstanding(pending_results)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// reset once
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("opinion_exchange_update_core_tb: FAIL");
		$finish;
	end

	// result sink: random backpressure by phase
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// one beat; returns at the edge where it is accepted
	task automatic send_item(input logic act, input logic [10:0] agent,
			input logic [10:0] partner, input logic neg, input logic [1:0] lp,
			input logic [15:0] lq);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		// agent, partner, neg, load_public, load_private, zero pad
		s_tdata  <= {7'd0, lq, lp, neg, partner, agent};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (8) @(posedge clk);   // extra margin after the last result
	endtask

	task automatic set_regs(input logic [15:0] g, input logic [15:0] t);
		drain();
		cfg_wen   <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// mostly a small pool so interactions hit loaded agents; repeats send the
	// same agent back to back
	function automatic logic [10:0] pick_agent();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 11'($urandom_range(15));
		if (r < 70) return last_agent;
		if (r < 80) return 11'(2047 - $urandom_range(3));
		return 11'($urandom_range(2047));
	endfunction

	function automatic logic [15:0] pick_private();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 16'($urandom_range(32768) - 16384);
		if (r < 65) begin
			case ($urandom_range(2))
				0: return 16'h4000;      // +1.0
				1: return 16'hC000;      // -1.0
				default: return 16'h0000;
			endcase
		end
		if (r < 80) return 16'($urandom_range(400) - 200);
		return 16'($urandom);            // often out of range, gets clamped
	endfunction

	task automatic random_item();
		logic        act;
		logic [10:0] agent;
		logic [10:0] partner;
		act     = ($urandom_range(99) < 28) ? ACT_LOAD : ACT_INTERACT;
		agent   = pick_agent();
		partner = ($urandom_range(99) < 8) ? agent : pick_agent();
		send_item(act, agent, partner, 1'($urandom_range(1)), 2'($urandom_range(3)),
			pick_private());
		last_agent = agent;
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);

		// default register values, written explicitly
		set_regs(16'(GAIN_RESET), THR_RESET);

		// directed: fresh memory, self interaction on an all-zero store
		send_item(ACT_INTERACT, 11'd0, 11'd0, 1'b0, 2'b00, 16'h0000);
		// loads: extremes, -2 pattern, out-of-range privates
		send_item(ACT_LOAD, 11'd0, 11'd2047, 1'b1, 2'b01, 16'h4000);
		send_item(ACT_LOAD, 11'd2047, 11'd0, 1'b0, 2'b10, 16'hC000);
		send_item(ACT_LOAD, 11'd1, 11'd0, 1'b0, 2'b00, 16'h7FFF);
		send_item(ACT_LOAD, 11'd2, 11'd0, 1'b0, 2'b01, 16'h8000);
		send_item(ACT_LOAD, 11'd3, 11'd0, 1'b0, 2'b11, 16'h4001);
		// add positive partner, private saturates high
		send_item(ACT_INTERACT, 11'd1, 11'd0, 1'b0, 2'b00, 16'h0000);
		// subtract negative partner: public clamps, then flips to private sign
		send_item(ACT_INTERACT, 11'd2, 11'd2047, 1'b1, 2'b00, 16'h0000);
		// agent equals partner, both signs
		send_item(ACT_INTERACT, 11'd0, 11'd0, 1'b1, 2'b00, 16'h0000);
		send_item(ACT_INTERACT, 11'd0, 11'd0, 1'b0, 2'b00, 16'h0000);
		send_item(ACT_INTERACT, 11'd2047, 11'd2047, 1'b0, 2'b00, 16'h0000);
		// zero private with a large gap: public stays
		send_item(ACT_LOAD, 11'd4, 11'd0, 1'b0, 2'b01, 16'h0000);
		send_item(ACT_INTERACT, 11'd4, 11'd5, 1'b0, 2'b00, 16'h0000);
		// back-to-back on one agent
		send_item(ACT_INTERACT, 11'd1, 11'd2, 1'b0, 2'b00, 16'h0000);
		send_item(ACT_INTERACT, 11'd1, 11'd2, 1'b0, 2'b00, 16'h0000);
		send_item(ACT_INTERACT, 11'd2, 11'd1, 1'b1, 2'b00, 16'h0000);
		send_item(ACT_INTERACT, 11'd1, 11'd2, 1'b1, 2'b00, 16'h0000);
		// all-ones fields on an interact
		send_item(ACT_INTERACT, 11'd2047, 11'd2047, 1'b1, 2'b11, 16'hFFFF);
		send_item(ACT_LOAD, 11'd1365, 11'd682, 1'b1, 2'b11, 16'hFFFF);
		send_item(ACT_INTERACT, 11'd682, 11'd1365, 1'b1, 2'b00, 16'h5555);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_regs(16'd0, 16'd32768);
				1: set_regs(16'd16383, 16'd0);
				2: set_regs(16'(GAIN_RESET), THR_RESET);
				3: set_regs(16'($urandom_range(16383)), 16'($urandom_range(32768)));
				4: set_regs(16'd4096, 16'd16384);
				5: set_regs(16'hFFFF, 16'hFFFF);
				6: set_regs(16'($urandom), 16'($urandom));
				default: set_regs(16'd1, 16'd1);
			endcase
			// idle mix: none, sender, receiver, both light
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			repeat (PHASE_BEATS) random_item();
		end

		drain();
		repeat (20) @(posedge clk);
		if (check_failures == 0 && pending_results == 0) begin
			$display("opinion_exchange_update_core_tb: PASS");
		end else begin
			$display("opinion_exchange_update_core_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/oeu_pkg.sv
rtl/oeu_front.sv
rtl/oeu_fifo.sv
rtl/oeu_back.sv
rtl/opinion_exchange_update_core.sv
bench/opinion_exchange_update_checker.sv
bench/opinion_exchange_update_core_tb.sv
